[hw/rtl/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler converter
// Payload structs, fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

	// Term width: 2*(ab+cd) of two Q1.14 products, Q28
	localparam int TERM_W = 34;
	// CORDIC x/y datapath width, room for pre-rotation and gain
	localparam int CW = 37;
	// Angle accumulator width, degrees * 2^16
	localparam int ZW = 26;
	// Angle in 1/128 degree before clamping
	localparam int UNIT_W = ZW - 8;
	// Square root: result bits and radicand width
	localparam int SQRT_BITS = 29;
	localparam int REM_W = 57;
	// Small pitch operand, |s| <= 1.0 in Q28
	localparam int SY_W = 30;
	localparam int TABLE_LEN = 24;
	localparam int QUEUE_DEPTH = 8;

	localparam logic signed [TERM_W-1:0] ONE_Q28 = 34'sd268435456;
	localparam logic signed [TERM_W-1:0] NEG_ONE_Q28 = -34'sd268435456;
	localparam logic [REM_W:0] ONE_Q56 = 58'd72057594037927936;
	localparam logic signed [ZW-1:0] Z_90 = 26'sd5898240;
	localparam logic signed [UNIT_W-1:0] PITCH_LIM = 18'sd11520;
	localparam logic signed [UNIT_W-1:0] ANGLE_LIM = 18'sd23040;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} qte_quat_t;

	typedef struct packed {
		logic signed [14:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic signed [15:0] yaw_angle;
		logic               asin_saturated;
	} qte_euler_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic signed [TERM_W-1:0] ra;
		logic signed [TERM_W-1:0] rb;
		logic signed [TERM_W-1:0] ya;
		logic signed [TERM_W-1:0] yb;
		logic signed [SY_W-1:0]   s_y;
		logic                     sat;
		logic                     neg;
		logic [REM_W-1:0]         rad;
	} qte_entry_t;

	// atan(2^-i) in degrees * 2^16, rounded
	function automatic logic signed [ZW-1:0] atan_deg16(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 26'sd2949120;
			1: r = 26'sd1740967;
			2: r = 26'sd919879;
			3: r = 26'sd466945;
			4: r = 26'sd234379;
			5: r = 26'sd117304;
			6: r = 26'sd58666;
			7: r = 26'sd29335;
			8: r = 26'sd14668;
			9: r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/quaternion_to_euler_angles_top.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: attitude quaternion to Euler angles
// Converts a Q1.14 quaternion to pitch, roll and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
// Usage:
//   quat channel: quat_valid / quat_stall, payload quat (w, x, y, z).
//   euler channel: euler_valid / euler_stall, payload euler (pitch, roll,
//   yaw, asin_saturated). A transaction completes when valid is high and
//   stall is low at a rising edge of clk.
//   From input transaction to result valid an item passes 4 front stages
//   (the first loads at the input edge), the queue, a root load stage,
//   29 square root stages (one root bit each), CORDIC_STEPS + 1 CORDIC
//   stages and the result register.
//   Throughput is one transaction per cycle; every stage is a pipeline
//   register, so the sustained rate is set only by the output side.
//   quat_stall is registered and rises when the queue plus the front
//   pipeline hold eight items.
//   When euler_stall and euler_valid are high the back pipeline freezes
//   and the result holds; the front keeps draining into the queue.
//   Reset (arst_n low) empties the pipelines and the queue; no transaction
//   is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_top import qte_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       quat_valid,
	output logic       quat_stall,
	input  qte_quat_t  quat,
	output logic       euler_valid,
	input  logic       euler_stall,
	output qte_euler_t euler
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	logic take;
	logic entry_valid;
	qte_entry_t entry, head;
	logic q_empty, q_pop;
	logic [OCC_W-1:0] occ_q, occ_next;
	logic stall_q;

	assign take = quat_valid && !stall_q;

	qte_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.quat        (quat),
		.entry_valid (entry_valid),
		.entry       (entry)
	);

	qte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (entry_valid),
		.push_data (entry),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty)
	);

	qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (q_pop),
		.res_valid (euler_valid),
		.res_stall (euler_stall),
		.res       (euler)
	);

	// Count items held in the front and the queue; stall on a full count
	assign occ_next = occ_q + OCC_W'(take) - OCC_W'(q_pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			stall_q <= 1'b0;
		end else begin
			occ_q   <= occ_next;
			stall_q <= (occ_next >= OCC_W'(QUEUE_DEPTH));
		end
	end

	assign quat_stall = stall_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("front and queue hold more items than the queue depth");

	a_queue_counted: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> occ_q != '0)
		else $error("queue holds an item the occupancy count does not see");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		quat_stall |-> occ_q == OCC_W'(QUEUE_DEPTH))
		else $error("input stalled while the queue has room");

endmodule

`default_nettype wire

[hw/rtl/qte_front.sv]
// ----------------------------------------------------------------------------
// qte_front: product, term and classification pipeline
// Forms the Q28 terms, flags asin saturation and builds the sqrt radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front import qte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  qte_quat_t  quat,
	output logic       entry_valid,
	output qte_entry_t entry
);

	logic [3:0] vld_q;

	logic signed [31:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_zz_s1;
	logic signed [31:0] p_wz_s1, p_xy_s1, p_wy_s1, p_zx_s1;
	logic signed [TERM_W-1:0] s_c;
	logic [SQRT_BITS-1:0] s_abs;
	qte_entry_t e_s2, e_s3, e_s4;
	qte_entry_t e3_rad;
	logic [REM_W:0] sq_s3;

	// Advance valid bits; the front never stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], take};
		end
	end

	// Stage 1: products
	always_ff @(posedge clk) begin
		p_wx_s1 <= quat.quat_w * quat.quat_x;
		p_yz_s1 <= quat.quat_y * quat.quat_z;
		p_xx_s1 <= quat.quat_x * quat.quat_x;
		p_yy_s1 <= quat.quat_y * quat.quat_y;
		p_zz_s1 <= quat.quat_z * quat.quat_z;
		p_wz_s1 <= quat.quat_w * quat.quat_z;
		p_xy_s1 <= quat.quat_x * quat.quat_y;
		p_wy_s1 <= quat.quat_w * quat.quat_y;
		p_zx_s1 <= quat.quat_z * quat.quat_x;
	end

	assign s_c = (TERM_W'(p_wy_s1) - TERM_W'(p_zx_s1)) <<< 1;

	// Stage 2: terms and asin classification
	always_ff @(posedge clk) begin
		e_s2.ra  <= (TERM_W'(p_wx_s1) + TERM_W'(p_yz_s1)) <<< 1;
		e_s2.rb  <= ONE_Q28 - ((TERM_W'(p_xx_s1) + TERM_W'(p_yy_s1)) <<< 1);
		e_s2.ya  <= (TERM_W'(p_wz_s1) + TERM_W'(p_xy_s1)) <<< 1;
		e_s2.yb  <= ONE_Q28 - ((TERM_W'(p_yy_s1) + TERM_W'(p_zz_s1)) <<< 1);
		e_s2.sat <= (s_c > ONE_Q28) || (s_c < NEG_ONE_Q28);
		e_s2.neg <= s_c[TERM_W-1];
		e_s2.s_y <= ((s_c > ONE_Q28) || (s_c < NEG_ONE_Q28)) ? '0 : SY_W'(s_c);
		e_s2.rad <= '0;
	end

	assign s_abs = e_s2.s_y[SY_W-1] ? SQRT_BITS'(-e_s2.s_y) : SQRT_BITS'(e_s2.s_y);

	// Stage 3: square the pitch operand
	always_ff @(posedge clk) begin
		e_s3  <= e_s2;
		sq_s3 <= (REM_W+1)'(s_abs) * (REM_W+1)'(s_abs);
	end

	// Fill in the radicand 1 - s^2 in Q56
	always_comb begin
		e3_rad     = e_s3;
		e3_rad.rad = REM_W'(ONE_Q56 - sq_s3);
	end

	// Stage 4: hold the completed entry
	always_ff @(posedge clk) begin
		e_s4 <= e3_rad;
	end

	assign entry_valid = vld_q[3];
	assign entry       = e_s4;

endmodule

`default_nettype wire

[hw/rtl/qte_queue.sv]
// ----------------------------------------------------------------------------
// qte_queue: short queue between front and back
// Register-based FIFO with a head read port; depth from the package.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_queue import qte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qte_entry_t push_data,
	input  logic       pop,
	output qte_entry_t head,
	output logic       empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qte_entry_t mem_q [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);

endmodule

`default_nettype wire

[hw/rtl/qte_cordic.sv]
// ----------------------------------------------------------------------------
// qte_cordic: pipelined CORDIC atan2 in vectoring mode
// Quadrant pre-rotation stage, then one stage per iteration; angle in
// degrees * 2^16, zero when both operands are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic import qte_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [TERM_W-1:0] op_y,
	input  logic signed [TERM_W-1:0] op_x,
	output logic signed [ZW-1:0]     angle
);

	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];
	logic                 zero_s [0:STEPS];

	// Pre-rotate by +/-90 degrees for a negative x operand
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (op_x == '0) && (op_y == '0);
			if (op_x[TERM_W-1]) begin
				if (!op_y[TERM_W-1]) begin
					x_s[0] <= CW'(op_y);
					y_s[0] <= -CW'(op_x);
					z_s[0] <= Z_90;
				end else begin
					x_s[0] <= -CW'(op_y);
					y_s[0] <= CW'(op_x);
					z_s[0] <= -Z_90;
				end
			end else begin
				x_s[0] <= CW'(op_x);
				y_s[0] <= CW'(op_y);
				z_s[0] <= '0;
			end
		end
	end

	// One micro-rotation per stage
	for (genvar i = 1; i <= STEPS; i++) begin : g_iter
		localparam int SH = i - 1;
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i-1] >>> SH;
		assign dy = x_s[i-1] >>> SH;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i] <= zero_s[i-1];
				if (!y_s[i-1][CW-1]) begin
					x_s[i] <= x_s[i-1] + dx;
					y_s[i] <= y_s[i-1] - dy;
					z_s[i] <= z_s[i-1] + atan_deg16(SH);
				end else begin
					x_s[i] <= x_s[i-1] - dx;
					y_s[i] <= y_s[i-1] + dy;
					z_s[i] <= z_s[i-1] - atan_deg16(SH);
				end
			end
		end
	end

	assign angle = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule

`default_nettype wire

[hw/rtl/qte_back.sv]
// ----------------------------------------------------------------------------
// qte_back: square root, three CORDIC pipelines and output register
// Pulls classified items from the queue and holds everything while the
// result register is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_back import qte_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  qte_entry_t head,
	input  logic       empty,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_stall,
	output qte_euler_t res
);

	logic en;
	logic out_vld_q;

	logic [SQRT_BITS:0]   sq_vld;
	qte_entry_t           sq_e   [0:SQRT_BITS];
	logic [REM_W-1:0]     sq_rem [0:SQRT_BITS];
	logic [SQRT_BITS-1:0] sq_r   [0:SQRT_BITS];

	logic [CORDIC_STEPS:0] cd_vld, cd_sat, cd_neg;

	logic signed [ZW-1:0] pitch_z, roll_z, yaw_z;
	logic signed [UNIT_W-1:0] pitch_u, roll_u, yaw_u;
	qte_euler_t res_q;

	function automatic logic signed [UNIT_W-1:0] to_units(
		input logic signed [ZW-1:0] acc,
		input logic signed [UNIT_W-1:0] lim
	);
		logic signed [ZW:0] sum;
		logic signed [UNIT_W-1:0] v;
		sum = (ZW+1)'(acc) + (ZW+1)'(256);
		v = sum[ZW:9];
		if (v > lim) begin
			v = lim;
		end
		if (v < -lim) begin
			v = -lim;
		end
		return v;
	endfunction

	assign en  = !(out_vld_q && res_stall);
	assign pop = en && !empty;

	// Advance valid and side bits through sqrt and CORDIC stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld    <= '0;
			cd_vld    <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			sq_vld    <= {sq_vld[SQRT_BITS-1:0], !empty};
			cd_vld    <= {cd_vld[CORDIC_STEPS-1:0], sq_vld[SQRT_BITS]};
			out_vld_q <= cd_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cd_sat <= {cd_sat[CORDIC_STEPS-1:0], sq_e[SQRT_BITS].sat};
			cd_neg <= {cd_neg[CORDIC_STEPS-1:0], sq_e[SQRT_BITS].neg};
		end
	end

	// Load the square root from the queue head
	always_ff @(posedge clk) begin
		if (en) begin
			sq_e[0]   <= head;
			sq_rem[0] <= head.rad;
			sq_r[0]   <= '0;
		end
	end

	// One root bit per stage, most significant first
	for (genvar j = 1; j <= SQRT_BITS; j++) begin : g_sqrt
		localparam int K = SQRT_BITS - j;
		logic [REM_W:0] trial;
		logic ge;
		assign trial = ((REM_W+1)'(sq_r[j-1]) << (K + 1)) | ((REM_W+1)'(1) << (2 * K));
		assign ge = {1'b0, sq_rem[j-1]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_e[j]   <= sq_e[j-1];
				sq_rem[j] <= ge ? REM_W'({1'b0, sq_rem[j-1]} - trial) : sq_rem[j-1];
				sq_r[j]   <= ge ? (sq_r[j-1] | (SQRT_BITS'(1) << K)) : sq_r[j-1];
			end
		end
	end

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk   (clk),
		.en    (en),
		.op_y  (TERM_W'(sq_e[SQRT_BITS].s_y)),
		.op_x  (TERM_W'({1'b0, sq_r[SQRT_BITS]})),
		.angle (pitch_z)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk   (clk),
		.en    (en),
		.op_y  (sq_e[SQRT_BITS].ra),
		.op_x  (sq_e[SQRT_BITS].rb),
		.angle (roll_z)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk   (clk),
		.en    (en),
		.op_y  (sq_e[SQRT_BITS].ya),
		.op_x  (sq_e[SQRT_BITS].yb),
		.angle (yaw_z)
	);

	assign pitch_u = cd_sat[CORDIC_STEPS] ?
		(cd_neg[CORDIC_STEPS] ? -PITCH_LIM : PITCH_LIM) : to_units(pitch_z, PITCH_LIM);
	assign roll_u = to_units(roll_z, ANGLE_LIM);
	assign yaw_u  = to_units(yaw_z, ANGLE_LIM);

	// Round, clamp and hold the result
	always_ff @(posedge clk) begin
		if (en) begin
			res_q.pitch_angle    <= pitch_u[14:0];
			res_q.roll_angle     <= roll_u[15:0];
			res_q.yaw_angle      <= yaw_u[15:0];
			res_q.asin_saturated <= cd_sat[CORDIC_STEPS];
		end
	end

	assign res_valid = out_vld_q;
	assign res       = res_q;

endmodule

`default_nettype wire

[verif/tb_quaternion_to_euler_angles_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_top: self-checking bench for the converter
// Drives directed and random quaternions with random idle and stall, predicts
// pitch, roll, yaw and the saturation flag in the bench, and compares each
// result transaction in order.
// ----------------------------------------------------------------------------

module tb_quaternion_to_euler_angles_top import qte_pkg::*; ;

	localparam int STEPS = 16;
	localparam int LATENCY = STEPS + 36;
	localparam int NUM_RANDOM = 1800;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint Q28 = 64'sd268435456;

	logic       clk;
	logic       arst_n;
	logic       quat_valid;
	logic       quat_stall;
	qte_quat_t  quat;
	logic       euler_valid;
	logic       euler_stall;
	qte_euler_t euler;

	int     mismatch_count;
	longint cycle_count = 0;
	bit     calm_stretch;

	quaternion_to_euler_angles_top #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat),
		.euler_valid(euler_valid), .euler_stall(euler_stall), .euler(euler)
	);

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what);
		$display("[%0t] ERROR %s", $realtime, what);
		mismatch_count++;
	endtask

	// Floor shift, same as an arithmetic right shift on 64 bits
	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(input longint n);
		longint lo, hi, mid;
		lo = 0;
		hi = 64'd4294967296;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint atan_entry(input int i);
		longint tbl [24];
		tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115,
			57, 29, 14, 7, 4, 2, 1, 0};
		return tbl[i];
	endfunction

	// Vectoring CORDIC, angle in degrees * 2^16
	function automatic longint vector_angle(input longint yi, input longint xi);
		longint xv, yv, zv, t, dx, dy;
		xv = xi;
		yv = yi;
		zv = 0;
		if (xv == 0 && yv == 0) return 0;
		if (xv < 0) begin
			t = xv;
			if (yv >= 0) begin
				xv = yv; yv = -t; zv = 90 * 65536;
			end else begin
				xv = -yv; yv = t; zv = -90 * 65536;
			end
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = floor_shift(yv, i);
			dy = floor_shift(xv, i);
			if (yv >= 0) begin
				xv += dx; yv -= dy; zv += atan_entry(i);
			end else begin
				xv -= dx; yv += dy; zv -= atan_entry(i);
			end
		end
		return zv;
	endfunction

	function automatic longint angle_units(input longint acc, input longint lim);
		longint v;
		v = floor_shift(acc + 256, 9);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v;
	endfunction

	function automatic qte_euler_t euler_of(input qte_quat_t q);
		qte_euler_t r;
		longint w, x, y, z, ra, rb, ya, yb, s, c, p;
		w = longint'(q.quat_w);
		x = longint'(q.quat_x);
		y = longint'(q.quat_y);
		z = longint'(q.quat_z);
		ra = 2 * (w * x + y * z);
		rb = Q28 - 2 * (x * x + y * y);
		ya = 2 * (w * z + x * y);
		yb = Q28 - 2 * (y * y + z * z);
		s = 2 * (w * y - z * x);
		r.asin_saturated = 1'b0;
		if (s > Q28) begin
			p = 11520; r.asin_saturated = 1'b1;
		end else if (s < -Q28) begin
			p = -11520; r.asin_saturated = 1'b1;
		end else begin
			c = root_floor((Q28 * Q28) - s * s);
			p = angle_units(vector_angle(s, c), 11520);
		end
		r.pitch_angle = p[14:0];
		r.roll_angle = 16'(angle_units(vector_angle(ra, rb), 23040));
		r.yaw_angle = 16'(angle_units(vector_angle(ya, yb), 23040));
		return r;
	endfunction

	// In-order store of predicted angles
	class euler_scoreboard;
		qte_euler_t pending_angles[$];

		function void note_quat(input qte_quat_t q);
			pending_angles.push_back(euler_of(q));
		endfunction

		task check_euler(input qte_euler_t got);
			qte_euler_t exp_e;
			if (pending_angles.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
				return;
			end
			exp_e = pending_angles.pop_front();
			if (got.pitch_angle !== exp_e.pitch_angle)
				report_mismatch($sformatf("pitch got %0d exp %0d",
					got.pitch_angle, exp_e.pitch_angle));
			if (got.roll_angle !== exp_e.roll_angle)
				report_mismatch($sformatf("roll got %0d exp %0d",
					got.roll_angle, exp_e.roll_angle));
			if (got.yaw_angle !== exp_e.yaw_angle)
				report_mismatch($sformatf("yaw got %0d exp %0d",
					got.yaw_angle, exp_e.yaw_angle));
			if (got.asin_saturated !== exp_e.asin_saturated)
				report_mismatch($sformatf("flag got %0b exp %0b",
					got.asin_saturated, exp_e.asin_saturated));
		endtask
	endclass

	euler_scoreboard board;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Count cycles and end a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Note accepted quaternions, check accepted results
	always @(posedge clk) begin
		if (arst_n && quat_valid && !quat_stall) board.note_quat(quat);
		if (arst_n && euler_valid && !euler_stall) board.check_euler(euler);
	end

	// Random output stall, quiet during the calm stretch
	always @(posedge clk) begin
		if (!arst_n) euler_stall <= 1'b0;
		else euler_stall <= !calm_stretch && ($urandom_range(99) < 13);
	end

	function automatic logic signed [15:0] rand_component();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return 16'($urandom);
		if (pick == 1) return 16'($urandom_range(2)) * 16'sd16384 - 16'sd16384;
		return 16'($urandom_range(32768)) - 16'sd16384;
	endfunction

	// Random unit-ish quaternion, normalized in real arithmetic
	function automatic qte_quat_t rand_unit();
		qte_quat_t q;
		real a, b, c, d, n;
		a = real'($urandom_range(2000)) - 1000.0;
		b = real'($urandom_range(2000)) - 1000.0;
		c = real'($urandom_range(2000)) - 1000.0;
		d = real'($urandom_range(2000)) - 1000.0;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0) begin
			a = 1.0; n = 1.0;
		end
		q.quat_w = 16'($rtoi(a / n * 16384.0));
		q.quat_x = 16'($rtoi(b / n * 16384.0));
		q.quat_y = 16'($rtoi(c / n * 16384.0));
		q.quat_z = 16'($rtoi(d / n * 16384.0));
		return q;
	endfunction

	// Offer one quaternion, with a random idle gap first, hold until taken
	task automatic send_quat(input qte_quat_t q);
		while (!calm_stretch && $urandom_range(99) < 13) begin
			quat_valid <= 1'b0;
			@(posedge clk);
		end
		quat_valid <= 1'b1;
		quat <= q;
		@(posedge clk);
		while (quat_stall) @(posedge clk);
	endtask

	function automatic qte_quat_t make_quat(input int w, input int x, input int y, input int z);
		qte_quat_t q;
		q.quat_w = 16'(w);
		q.quat_x = 16'(x);
		q.quat_y = 16'(y);
		q.quat_z = 16'(z);
		return q;
	endfunction

	initial begin
		qte_quat_t directed[$];
		int waited;
		board = new();
		mismatch_count = 0;
		calm_stretch = 1'b0;
		arst_n = 1'b0;
		quat_valid = 1'b0;
		quat = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity, axes, zero operands, near-limit and beyond-range asin
		directed.push_back(make_quat(16384, 0, 0, 0));
		directed.push_back(make_quat(0, 0, 0, 0));
		directed.push_back(make_quat(0, 16384, 0, 0));
		directed.push_back(make_quat(0, 0, 16384, 0));
		directed.push_back(make_quat(0, 0, 0, 16384));
		directed.push_back(make_quat(-16384, 0, 0, 0));
		directed.push_back(make_quat(11585, 0, 11585, 0));
		directed.push_back(make_quat(11585, 0, -11585, 0));
		directed.push_back(make_quat(11586, 0, 11586, 0));
		directed.push_back(make_quat(11586, 0, -11586, 0));
		directed.push_back(make_quat(16384, 16384, 16384, 16384));
		directed.push_back(make_quat(-32768, -32768, -32768, -32768));
		directed.push_back(make_quat(32767, 32767, 32767, 32767));
		directed.push_back(make_quat(-32768, 32767, -32768, 32767));
		directed.push_back(make_quat(0, 11585, 11585, 0));
		directed.push_back(make_quat(0, 16384, 0, 16384));
		directed.push_back(make_quat(11585, 11585, 0, 0));
		directed.push_back(make_quat(11585, 0, 0, -11585));
		directed.push_back(make_quat(-1, -1, -1, -1));
		directed.push_back(make_quat(1, 1, 1, 1));
		foreach (directed[i]) send_quat(directed[i]);

		// Random: mostly unit quaternions, some raw components
		for (int i = 0; i < NUM_RANDOM; i++) begin
			calm_stretch = (i >= 600 && i < 800);
			if ($urandom_range(3) == 0)
				send_quat(make_quat(rand_component(), rand_component(),
					rand_component(), rand_component()));
			else
				send_quat(rand_unit());
		end
		calm_stretch = 1'b0;
		quat_valid <= 1'b0;

		// Drain, then allow the pipeline latency
		waited = 0;
		while (board.pending_angles.size() != 0 && waited < 20 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		if (board.pending_angles.size() != 0)
			report_mismatch("results still pending at end");
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
